// ===== sv/ssq_pkg.sv =====
// ssq_pkg: shared types, constants and codes for the servo setpoint queue
// used by ssq_lane, ssq_queue and servo_setpoint_queue_top; no dependencies
package ssq_pkg;

  // queue geometry
  localparam int QDEPTH = 32;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QLW    = $clog2(QDEPTH + 1);

  // field widths
  localparam int ANGLE_W = 15;
  localparam int COUNT_W = 16;
  localparam int OFFS_W  = 12;
  localparam int LVL_W   = 6;
  localparam int PAIR_W  = 2 * COUNT_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // fixed point scaling of the inverse span product
  localparam int FRAC_W  = 28;

  // action codes
  localparam logic [1:0] ACT_ANGLE = 2'd0;
  localparam logic [1:0] ACT_RAW   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_QUEUED     = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_UPDATED    = 2'd2,
    ST_EMPTY_TICK = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_FIRST_MIN    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FIRST_INV    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FIRST_OFFS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SECOND_MIN   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SECOND_INV   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SECOND_OFFS  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_PULSE_MIN    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_PULSE_MAX    = 3'd7;

  // reset values of the configuration registers
  localparam logic [ANGLE_W-1:0] RST_FIRST_MIN   = 15'h736F;  // -3217
  localparam logic [COUNT_W-1:0] RST_FIRST_INV   = 16'd20861;
  localparam logic [OFFS_W-1:0]  RST_FIRST_OFFS  = 12'd30;
  localparam logic [ANGLE_W-1:0] RST_SECOND_MIN  = 15'h5A4D;  // -9651
  localparam logic [COUNT_W-1:0] RST_SECOND_INV  = 16'd20861;
  localparam logic [OFFS_W-1:0]  RST_SECOND_OFFS = 12'd60;
  localparam logic [COUNT_W-1:0] RST_PULSE_MIN   = 16'd250;
  localparam logic [COUNT_W-1:0] RST_PULSE_MAX   = 16'd1250;

  // per channel settings handed to one mapping lane
  typedef struct packed {
    logic [ANGLE_W-1:0] min_angle;
    logic [COUNT_W-1:0] inv_span;
    logic [OFFS_W-1:0]  offset;
  } lane_cfg_t;

  // queue commands from the control
  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  // queue status to the control
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QLW-1:0] level;
  } queue_stat_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_COMMIT
  } ctrl_state_t;

endpackage

// ===== sv/ssq_lane.sv =====
// ssq_lane: one channel of the angle to pulse count mapping, five register stages
// depends on ssq_pkg
module ssq_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssq_pkg::ANGLE_W-1:0] angle,
  input  ssq_pkg::lane_cfg_t          cfg,
  input  logic [ssq_pkg::COUNT_W-1:0] pulse_min,
  input  logic [ssq_pkg::COUNT_W-1:0] pulse_max,
  output logic                        done,
  output logic [ssq_pkg::COUNT_W-1:0] count
);
  import ssq_pkg::*;

  localparam int DW  = ANGLE_W + 1;          // angle difference
  localparam int P1W = DW + COUNT_W + 1;     // difference times inverse span
  localparam int SW  = COUNT_W + 1;          // signed bound span
  localparam int P2W = P1W + SW;             // full product
  localparam int NW  = P2W + 1;              // numerator with base added
  localparam int QW  = NW - FRAC_W;          // integer part

  logic [4:0]                valid_r;
  logic signed [DW-1:0]      d_r, d_nxt;
  logic signed [P1W-1:0]     p1_r;
  logic signed [P2W-1:0]     p2_r;
  logic [COUNT_W-1:0]        clamp_r, clamp_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic signed [COUNT_W:0]   inv_s;
  logic signed [SW-1:0]      span_s;
  logic signed [NW-1:0]      num;
  logic                      adj;
  logic signed [QW-1:0]      q, hi_s, lo_s, t_hi, t_lo;
  logic [COUNT_W:0]          sum;

  // valid token through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[3:0], start};
    end
  end

  // stage 0: offset from the channel's lowest angle
  assign d_nxt = $signed({angle[ANGLE_W-1], angle})
               - $signed({cfg.min_angle[ANGLE_W-1], cfg.min_angle});

  // signed views of the unsigned settings
  assign inv_s  = $signed({1'b0, cfg.inv_span});
  assign span_s = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});

  // stage 3: add base, truncate toward zero, clamp high then low
  assign num  = $signed({p2_r[P2W-1], p2_r})
              + $signed({{(NW-COUNT_W-FRAC_W){1'b0}}, pulse_min, {FRAC_W{1'b0}}});
  assign adj  = num[NW-1] & (|num[FRAC_W-1:0]);
  assign q    = $signed(num[NW-1:FRAC_W]) + $signed({{(QW-1){1'b0}}, adj});
  assign hi_s = $signed({{(QW-COUNT_W){1'b0}}, pulse_max});
  assign lo_s = $signed({{(QW-COUNT_W){1'b0}}, pulse_min});
  assign t_hi = (q > hi_s) ? hi_s : q;
  assign t_lo = (t_hi < lo_s) ? lo_s : t_hi;
  assign clamp_nxt = t_lo[COUNT_W-1:0];

  // stage 4: trim with saturation
  assign sum       = {1'b0, clamp_r} + {{(COUNT_W+1-OFFS_W){1'b0}}, cfg.offset};
  assign count_nxt = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

  // datapath registers, multiplies in stages 1 and 2
  always_ff @(posedge clk) begin
    if (start)      d_r     <= d_nxt;
    if (valid_r[0]) p1_r    <= d_r * inv_s;
    if (valid_r[1]) p2_r    <= p1_r * span_s;
    if (valid_r[2]) clamp_r <= clamp_nxt;
    if (valid_r[3]) count_r <= count_nxt;
  end

  assign done  = valid_r[4];
  assign count = count_r;

endmodule

// ===== sv/ssq_queue.sv =====
// ssq_queue: pair store with write and read pointers and fill count
// depends on ssq_pkg
module ssq_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssq_pkg::queue_cmd_t        cmd,
  input  logic [ssq_pkg::PAIR_W-1:0] wr_data,
  output logic [ssq_pkg::PAIR_W-1:0] rd_data,
  output ssq_pkg::queue_stat_t       stat
);
  import ssq_pkg::*;

  logic [PAIR_W-1:0] mem [QDEPTH];
  logic [PAIR_W-1:0] rd_data_r;
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QLW-1:0]    fill_r, fill_nxt;

  // pointer advance with wrap at the queue depth
  assign wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push && !cmd.pop) begin
      fill_nxt = fill_r + QLW'(1);
    end else if (cmd.pop && !cmd.push) begin
      fill_nxt = fill_r - QLW'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (cmd.push) wr_ptr_r <= wr_ptr_nxt;
      if (cmd.pop)  rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // store, head entry read into a register every cycle
  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_ptr_r] <= wr_data;
    rd_data_r <= mem[rd_ptr_r];
  end

  assign rd_data    = rd_data_r;
  assign stat.full  = (fill_r == QLW'(QDEPTH));
  assign stat.empty = (fill_r == '0);
  assign stat.level = fill_r;

endmodule

// ===== sv/servo_setpoint_queue_top.sv =====
// servo_setpoint_queue_top: configuration registers, sequencer, two mapping lanes,
// merge into the pair queue, compare registers and output register
// depends on ssq_pkg, ssq_lane, ssq_queue
//
// Usage:
//  - in_* channel takes one item: an angle pair, a raw pair or a period tick.
//    Every item yields exactly one result on the out_* channel with a status,
//    the compare values after the item and the number of queued pairs.
//  - cfg_we/cfg_addr/cfg_wdata write one of eight settings while the block
//    is idle; writes take effect at once, there is no read-back.
//  - an angle item runs through two lanes of five register stages, one per
//    channel, with two multiplies each; the result is registered after the
//    lanes finish, and the next item is taken only once it is registered.
//  - raw and tick items skip the lanes and go straight to the commit state;
//    the result is registered there once the output register is free.
//  - the result sits in an output register; while out_stall holds it, the
//    next item is still accepted and mapped, and it completes once the
//    register frees.
//  - a full queue rejects the pair; a tick on an empty queue keeps the
//    compare values.
//  - synchronous reset clears pointers, fill count, compare values, the
//    sequencer and restores the default settings; no clearing pass is needed.
module servo_setpoint_queue_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [ssq_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ssq_pkg::CFG_DW-1:0] cfg_wdata,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [14:0]                in_angle_x,
  input  logic [14:0]                in_angle_y,
  input  logic [15:0]                in_raw_first,
  input  logic [15:0]                in_raw_second,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [15:0]                out_compare_first,
  output logic [15:0]                out_compare_second,
  output logic [5:0]                 out_queue_level
);
  import ssq_pkg::*;

  // configuration registers
  lane_cfg_t          first_cfg_r, second_cfg_r;
  logic [COUNT_W-1:0] pulse_min_r, pulse_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cfg_r.min_angle  <= RST_FIRST_MIN;
      first_cfg_r.inv_span   <= RST_FIRST_INV;
      first_cfg_r.offset     <= RST_FIRST_OFFS;
      second_cfg_r.min_angle <= RST_SECOND_MIN;
      second_cfg_r.inv_span  <= RST_SECOND_INV;
      second_cfg_r.offset    <= RST_SECOND_OFFS;
      pulse_min_r            <= RST_PULSE_MIN;
      pulse_max_r            <= RST_PULSE_MAX;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FIRST_MIN:   first_cfg_r.min_angle  <= cfg_wdata[ANGLE_W-1:0];
        REG_FIRST_INV:   first_cfg_r.inv_span   <= cfg_wdata;
        REG_FIRST_OFFS:  first_cfg_r.offset     <= cfg_wdata[OFFS_W-1:0];
        REG_SECOND_MIN:  second_cfg_r.min_angle <= cfg_wdata[ANGLE_W-1:0];
        REG_SECOND_INV:  second_cfg_r.inv_span  <= cfg_wdata;
        REG_SECOND_OFFS: second_cfg_r.offset    <= cfg_wdata[OFFS_W-1:0];
        REG_PULSE_MIN:   pulse_min_r            <= cfg_wdata;
        REG_PULSE_MAX:   pulse_max_r            <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  ctrl_state_t        state_r, state_nxt;
  logic               accept, lane_start, out_free, commit;
  logic               is_pair;
  logic [1:0]         action_r;
  logic [COUNT_W-1:0] raw_first_r, raw_second_r;
  logic               done_x, done_y;
  logic [COUNT_W-1:0] count_x, count_y;

  assign out_free = !out_valid || !out_stall;
  assign is_pair  = (action_r == ACT_ANGLE) || (action_r == ACT_RAW);

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    accept     = 1'b0;
    lane_start = 1'b0;
    commit     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept     = 1'b1;
          lane_start = (in_action == ACT_ANGLE);
          state_nxt  = (in_action == ACT_ANGLE) ? S_MAP : S_COMMIT;
        end
      end
      S_MAP: begin
        if (done_x) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r     <= in_action;
      raw_first_r  <= in_raw_first;
      raw_second_r <= in_raw_second;
    end
  end

  // mapping lanes, one per channel
  ssq_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lane_start),
    .angle     (in_angle_x),
    .cfg       (first_cfg_r),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .done      (done_x),
    .count     (count_x)
  );

  ssq_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lane_start),
    .angle     (in_angle_y),
    .cfg       (second_cfg_r),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .done      (done_y),
    .count     (count_y)
  );

  // merge: pick the pair to queue
  logic [PAIR_W-1:0] pair_wdata;
  logic [PAIR_W-1:0] head_pair;
  queue_cmd_t        qcmd;
  queue_stat_t       qstat;

  assign pair_wdata = (action_r == ACT_ANGLE) ? {count_y, count_x}
                                               : {raw_second_r, raw_first_r};
  assign qcmd.push  = commit && is_pair && !qstat.full;
  assign qcmd.pop   = commit && !is_pair && !qstat.empty;

  ssq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (qcmd),
    .wr_data (pair_wdata),
    .rd_data (head_pair),
    .stat    (qstat)
  );

  // result of this item
  logic [PAIR_W-1:0] compare_r, compare_nxt;
  status_t           status_nxt;
  logic [QLW-1:0]    level_nxt;
  logic              lanes_agree;

  assign lanes_agree = done_x == done_y;

  always_comb begin
    compare_nxt = compare_r;
    level_nxt   = qstat.level;
    if (is_pair) begin
      if (qstat.full) begin
        status_nxt = ST_REJECTED;
      end else begin
        status_nxt = ST_QUEUED;
        level_nxt  = qstat.level + QLW'(1);
      end
    end else begin
      if (qstat.empty) begin
        status_nxt = ST_EMPTY_TICK;
      end else begin
        status_nxt  = ST_UPDATED;
        compare_nxt = head_pair;
        level_nxt   = qstat.level - QLW'(1);
      end
    end
  end

  // compare registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r <= '0;
    end else if (commit && lanes_agree) begin
      compare_r <= compare_nxt;
    end
  end

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [PAIR_W-1:0]   out_compare_r;
  logic [LVL_W-1:0]    out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r  <= status_nxt;
      out_compare_r <= compare_nxt;
      out_level_r   <= LVL_W'(level_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_compare_first  = out_compare_r[COUNT_W-1:0];
  assign out_compare_second = out_compare_r[PAIR_W-1:COUNT_W];
  assign out_queue_level    = out_level_r;

endmodule
